FILE: hw/rtl/tsdes_pkg.sv
`default_nettype none

package tsdes_pkg;

  // Register map, indexed by paddr[3:2]
  localparam logic [1:0] REG_FIRST_KEY   = 2'd0;
  localparam logic [1:0] REG_SECOND_KEY  = 2'd1;
  localparam logic [1:0] REG_TRIPLE_MODE = 2'd2;

  localparam int unsigned NUM_CELLS = 6;

  // Permutation tables, positions counted 1-based from the MSB
  localparam int unsigned IP_TBL  [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
  localparam int unsigned IPI_TBL [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
  localparam int unsigned P10_TBL [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
  localparam int unsigned P8_TBL  [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
  localparam int unsigned EP_TBL  [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
  localparam int unsigned P4_TBL  [4]  = '{2, 4, 3, 1};

  // S-boxes indexed by {row, col}
  localparam logic [1:0] S0_TBL [16] = '{
    2'd1, 2'd0, 2'd3, 2'd2,
    2'd3, 2'd2, 2'd1, 2'd0,
    2'd0, 2'd2, 2'd1, 2'd3,
    2'd3, 2'd1, 2'd3, 2'd2
  };
  localparam logic [1:0] S1_TBL [16] = '{
    2'd0, 2'd1, 2'd2, 2'd3,
    2'd2, 2'd0, 2'd1, 2'd3,
    2'd3, 2'd0, 2'd1, 2'd0,
    2'd2, 2'd1, 2'd0, 2'd3
  };

  // One pipeline slot: valid flag, decrypt command and the 8-bit block
  typedef struct packed {
    logic       valid;
    logic       dec;
    logic [7:0] blk;
  } stage_t;

  function automatic logic [7:0] perm_ip(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[8-IP_TBL[i]];
    return r;
  endfunction

  function automatic logic [7:0] perm_ipi(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[8-IPI_TBL[i]];
    return r;
  endfunction

  function automatic logic [9:0] perm_p10(input logic [9:0] v);
    logic [9:0] r;
    for (int i = 0; i < 10; i++) r[9-i] = v[10-P10_TBL[i]];
    return r;
  endfunction

  function automatic logic [7:0] perm_p8(input logic [9:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[10-P8_TBL[i]];
    return r;
  endfunction

  function automatic logic [7:0] perm_ep(input logic [3:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = v[4-EP_TBL[i]];
    return r;
  endfunction

  function automatic logic [3:0] perm_p4(input logic [3:0] v);
    logic [3:0] r;
    for (int i = 0; i < 4; i++) r[3-i] = v[4-P4_TBL[i]];
    return r;
  endfunction

  function automatic logic [1:0] sbox0(input logic [3:0] v);
    return S0_TBL[{v[3], v[0], v[2:1]}];
  endfunction

  function automatic logic [1:0] sbox1(input logic [3:0] v);
    return S1_TBL[{v[3], v[0], v[2:1]}];
  endfunction

  // Round function: expand, mix subkey, substitute, permute
  function automatic logic [3:0] feistel(input logic [3:0] half, input logic [7:0] sk);
    logic [7:0] x;
    x = perm_ep(half) ^ sk;
    return perm_p4({sbox0(x[7:4]), sbox1(x[3:0])});
  endfunction

  // Subkey 1: P10, rotate each half by one, P8
  function automatic logic [7:0] sched_k1(input logic [9:0] key);
    logic [9:0] p;
    p = perm_p10(key);
    return perm_p8({p[8:5], p[9], p[3:0], p[4]});
  endfunction

  // Subkey 2: P10, rotate each half by three in total, P8
  function automatic logic [7:0] sched_k2(input logic [9:0] key);
    logic [9:0] p;
    p = perm_p10(key);
    return perm_p8({p[6:5], p[9:7], p[1:0], p[4:2]});
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tsdes_round_cell.sv
`default_nettype none

module tsdes_round_cell import tsdes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] sub1,
  input  logic [7:0] sub2,
  input  logic       mid_pass,
  input  logic       odd_round,
  input  logic       bypass,
  input  stage_t     up,
  output logic       up_ready,
  output stage_t     down,
  input  logic       down_ready
);

  logic       use_k2;
  logic [7:0] sk;
  logic [3:0] mixed;
  logic [7:0] blk_next;

  assign up_ready = !down.valid || down_ready;

  // Decrypt order reverses the subkeys; the middle pass runs the opposite command
  assign use_k2   = up.dec ^ mid_pass ^ odd_round;
  assign sk       = use_k2 ? sub2 : sub1;
  assign mixed    = up.blk[7:4] ^ feistel(up.blk[3:0], sk);

  // Swap halves after the first round of a pass only
  always_comb begin
    if (bypass) begin
      blk_next = up.blk;
    end else if (odd_round) begin
      blk_next = {mixed, up.blk[3:0]};
    end else begin
      blk_next = {up.blk[3:0], mixed};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (up_ready) begin
      down.valid <= up.valid;
      if (up.valid) begin
        down.dec <= up.dec;
        down.blk <= blk_next;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    down.valid && !down_ready |=> down.valid && $stable(down.blk) && $stable(down.dec))
    else $error("stalled cell lost or changed its transaction");

  a_load: assert property (@(posedge clk) disable iff (rst)
    up.valid && up_ready |=> down.valid)
    else $error("accepted transaction not held by cell");

endmodule

`default_nettype wire

FILE: hw/rtl/triple_sdes_cipher.sv
`default_nettype none

// Channel   Dir  Payload                                   Handshake
// s_axis    in   tdata: data_in[7:0]; tuser: cmd          tvalid/tready
// m_axis    out  tdata: data_out[7:0]                      tvalid/tready
// apb       in   first_key, second_key, triple_mode       psel/penable/pready
//
// Six round cells in a row, one Feistel round each; a block passes the cell
// registers in turn; a new block may enter each cycle unless the chain is full.
// In single mode the last four cells pass the block through unchanged.
// Each cell holds its transaction until the next one frees, so bubbles close up
// and input is taken while a result waits on the output.
// Reset (synchronous) empties the cells and loads the register defaults.
module triple_sdes_cipher import tsdes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_out
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0] first_key;
  logic [9:0] second_key;
  logic       triple_mode;
  logic       cfg_wr;

  logic [7:0] k1_sub1;
  logic [7:0] k1_sub2;
  logic [7:0] k2_sub1;
  logic [7:0] k2_sub2;

  stage_t chain [NUM_CELLS+1];
  logic   ready [NUM_CELLS+1];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_key   <= 10'd0;
      second_key  <= 10'd0;
      triple_mode <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FIRST_KEY:   first_key   <= pwdata[9:0];
        REG_SECOND_KEY:  second_key  <= pwdata[9:0];
        REG_TRIPLE_MODE: triple_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FIRST_KEY:   prdata = {22'd0, first_key};
      REG_SECOND_KEY:  prdata = {22'd0, second_key};
      REG_TRIPLE_MODE: prdata = {31'd0, triple_mode};
      default:         prdata = 32'd0;
    endcase
  end

  assign k1_sub1 = sched_k1(first_key);
  assign k1_sub2 = sched_k2(first_key);
  assign k2_sub1 = sched_k1(second_key);
  assign k2_sub2 = sched_k2(second_key);

  // Initial permutation on entry; inner IP/IP^-1 pairs cancel between passes
  assign chain[0].valid = s_axis_tvalid;
  assign chain[0].dec   = s_axis_tuser;
  assign chain[0].blk   = perm_ip(s_axis_tdata);
  assign s_axis_tready  = ready[0];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    localparam bit MID = ((i / 2) == 1);
    localparam bit ODD = ((i % 2) == 1);
    localparam bit OUTER_ONLY = (i < 2);

    tsdes_round_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .sub1       (MID ? k2_sub1 : k1_sub1),
      .sub2       (MID ? k2_sub2 : k1_sub2),
      .mid_pass   (MID),
      .odd_round  (ODD),
      .bypass     (!OUTER_ONLY && !triple_mode),
      .up         (chain[i]),
      .up_ready   (ready[i]),
      .down       (chain[i+1]),
      .down_ready (ready[i+1])
    );
  end

  assign m_axis_tvalid     = chain[NUM_CELLS].valid;
  assign m_axis_tdata      = perm_ipi(chain[NUM_CELLS].blk);
  assign ready[NUM_CELLS]  = m_axis_tready;

  a_mode_wr: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && paddr[3:2] == REG_TRIPLE_MODE |=> triple_mode == $past(pwdata[0]))
    else $error("mode register write not taken");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

FILE: tb/triple_sdes_cipher_tb.sv
`timescale 1ns / 1ps

module triple_sdes_cipher_tb;
  import tsdes_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned PHASE_ITEMS = 122;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Bit selections, 1-based from the MSB of the source word
  localparam int IP_POS  [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
  localparam int IPI_POS [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
  localparam int P10_POS [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
  localparam int P8_POS  [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
  localparam int EP_POS  [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
  localparam int P4_POS  [4]  = '{2, 4, 3, 1};
  // Substitution boxes, row-major, row = {b3,b0}, column = {b2,b1}
  localparam int SUB0 [16] = '{1, 0, 3, 2, 3, 2, 1, 0, 0, 2, 1, 3, 3, 1, 3, 2};
  localparam int SUB1 [16] = '{0, 1, 2, 3, 2, 0, 1, 3, 3, 0, 1, 0, 2, 1, 0, 3};

  typedef enum {PERM_IP, PERM_IPI, PERM_P10, PERM_P8, PERM_EP, PERM_P4} perm_t;
  typedef enum logic {CMD_ENCRYPT = 1'b0, CMD_DECRYPT = 1'b1} cmd_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_in
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] data_out
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [9:0]  cfg_first_key;
  logic [9:0]  cfg_second_key;
  logic        cfg_triple;

  logic [7:0]  pending_blocks[$];
  logic [7:0]  want_block;
  bit          src_idle_en;
  bit          snk_stall_en;
  int unsigned stall_left;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_phases;
  int unsigned n_errors;

  triple_sdes_cipher u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [9:0] remap(input logic [9:0] v, input int in_w, input perm_t p);
    logic [9:0] r;
    int n;
    int pos;
    r = '0;
    pos = 1;
    case (p)
      PERM_P10: n = 10;
      PERM_P4:  n = 4;
      default:  n = 8;
    endcase
    for (int i = 0; i < n; i++) begin
      case (p)
        PERM_IP:  pos = IP_POS[i];
        PERM_IPI: pos = IPI_POS[i];
        PERM_P10: pos = P10_POS[i];
        PERM_P8:  pos = P8_POS[i];
        PERM_EP:  pos = EP_POS[i];
        PERM_P4:  pos = P4_POS[i];
        default:  pos = 1;
      endcase
      r = {r[8:0], v[in_w - pos]};
    end
    return r;
  endfunction

  function automatic logic [4:0] rot5(input logic [4:0] v, input int s);
    logic [9:0] w;
    w = {v, v} >> (5 - s);
    return w[4:0];
  endfunction

  // Returns {subkey1, subkey2}
  function automatic logic [15:0] subkeys(input logic [9:0] key);
    logic [9:0] p;
    logic [4:0] lh;
    logic [4:0] rh;
    logic [9:0] k1;
    logic [9:0] k2;
    p  = remap(key, 10, PERM_P10);
    lh = rot5(p[9:5], 1);
    rh = rot5(p[4:0], 1);
    k1 = remap({lh, rh}, 10, PERM_P8);
    lh = rot5(lh, 2);
    rh = rot5(rh, 2);
    k2 = remap({lh, rh}, 10, PERM_P8);
    return {k1[7:0], k2[7:0]};
  endfunction

  function automatic logic [3:0] round_f(input logic [3:0] half, input logic [7:0] sk);
    logic [9:0] e;
    logic [7:0] x;
    logic [1:0] s0;
    logic [1:0] s1;
    logic [9:0] p;
    e  = remap({6'd0, half}, 4, PERM_EP);
    x  = e[7:0] ^ sk;
    s0 = 2'(SUB0[{x[7], x[4], x[6:5]}]);
    s1 = 2'(SUB1[{x[3], x[0], x[2:1]}]);
    p  = remap({6'd0, s0, s1}, 4, PERM_P4);
    return p[3:0];
  endfunction

  function automatic logic [7:0] sdes_pass(input logic [9:0] key, input logic [7:0] blk,
                                           input logic dec);
    logic [15:0] ks;
    logic [7:0]  ka;
    logic [7:0]  kb;
    logic [9:0]  t;
    logic [3:0]  lh;
    logic [3:0]  rh;
    ks = subkeys(key);
    ka = dec ? ks[7:0] : ks[15:8];
    kb = dec ? ks[15:8] : ks[7:0];
    t  = remap({2'd0, blk}, 8, PERM_IP);
    lh = t[7:4] ^ round_f(t[3:0], ka);
    rh = t[3:0] ^ round_f(lh, kb);
    t  = remap({2'd0, rh, lh}, 8, PERM_IPI);
    return t[7:0];
  endfunction

  function automatic logic [7:0] ede_result(input logic dec, input logic [7:0] blk);
    logic [7:0] d;
    d = sdes_pass(cfg_first_key, blk, dec);
    if (cfg_triple) begin
      d = sdes_pass(cfg_second_key, d, !dec);
      d = sdes_pass(cfg_first_key, d, dec);
    end
    return d;
  endfunction

  // ---------------------------------------------------------------- bus tasks

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_FIRST_KEY:   cfg_first_key  = value[9:0];
      REG_SECOND_KEY:  cfg_second_key = value[9:0];
      REG_TRIPLE_MODE: cfg_triple     = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      n_errors++;
      $display("%0t: register %0d read expected %08h got %08h", $time, idx, want, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    reg_check(REG_FIRST_KEY, {22'd0, cfg_first_key});
    reg_check(REG_SECOND_KEY, {22'd0, cfg_second_key});
    reg_check(REG_TRIPLE_MODE, {31'd0, cfg_triple});
  endtask

  task automatic load_config(input logic [31:0] k1, input logic [31:0] k2,
                             input logic [31:0] mode);
    reg_write(REG_FIRST_KEY, k1);
    reg_write(REG_SECOND_KEY, k2);
    reg_write(REG_TRIPLE_MODE, mode);
    check_all_regs();
  endtask

  // -------------------------------------------------------------- stream side

  // Leaves tvalid high after the transaction so back-to-back blocks need no drop
  task automatic send_block(input cmd_t cmd, input logic [7:0] blk);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    pending_blocks.push_back(ede_result(cmd, blk));
    n_sent++;
  endtask

  task automatic send_both(input logic [7:0] blk);
    send_block(CMD_ENCRYPT, blk);
    send_block(CMD_DECRYPT, blk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sink backpressure: one assignment per falling edge
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (snk_stall_en && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(1, 8) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_blocks.size() == 0) begin
        n_errors++;
        $display("%0t: data_out %02h arrived with no block outstanding", $time, m_axis_tdata);
      end else begin
        want_block = pending_blocks.pop_front();
        n_checked++;
        if (m_axis_tdata !== want_block) begin
          n_errors++;
          $display("%0t: data_out expected %02h got %02h", $time, want_block, m_axis_tdata);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    check_all_regs();
    send_block(CMD_ENCRYPT, 8'h00);
    send_block(CMD_DECRYPT, 8'hFF);
    drain();
  endtask

  task automatic test_directed_vectors();
    // textbook single-pass vector: key 1010000010, 10010111 <-> 00111000
    load_config(32'h282, 32'h000, 32'd0);
    send_block(CMD_ENCRYPT, 8'h97);
    send_block(CMD_DECRYPT, 8'h38);
    send_both(8'h00);
    send_both(8'hFF);
    send_block(CMD_ENCRYPT, 8'hAA);
    send_block(CMD_DECRYPT, 8'h55);
    drain();
    n_phases++;
    load_config(32'h3FF, 32'h000, 32'd1);
    send_both(8'h00);
    send_both(8'hFF);
    send_both(8'h01);
    send_both(8'h80);
    drain();
    n_phases++;
  endtask

  task automatic test_register_masking();
    // upper bits must be dropped; the unused slot must not disturb anything
    load_config(32'hFFFF_FD5A, 32'hAAAA_A8A5, 32'hFFFF_FFFE);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    check_all_regs();
    send_block(CMD_ENCRYPT, 8'h3C);
    send_block(CMD_DECRYPT, 8'hC3);
    drain();
    n_phases++;
  endtask

  task automatic run_phase(input logic [31:0] k1, input logic [31:0] k2,
                           input logic [31:0] mode);
    load_config(k1, k2, mode);
    repeat (PHASE_ITEMS) begin
      send_block(cmd_t'($urandom_range(0, 1)), 8'($urandom()));
    end
    drain();
    n_phases++;
  endtask

  task automatic test_random_phases();
    run_phase(32'h000, 32'h000, 32'd0);
    run_phase(32'h3FF, 32'h3FF, 32'd1);
    run_phase(32'h3FF, 32'h000, 32'd0);
    run_phase(32'h000, 32'h3FF, 32'd1);
    run_phase($urandom(), $urandom(), $urandom());
    run_phase($urandom(), $urandom(), 32'd1);
    run_phase($urandom(), $urandom(), 32'd0);
    // steady full-rate stream to finish
    src_idle_en  = 1'b0;
    snk_stall_en = 1'b0;
    run_phase($urandom(), $urandom(), $urandom());
  endtask

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cfg_first_key  = '0;
    cfg_second_key = '0;
    cfg_triple     = 1'b1;
    src_idle_en    = 1'b1;
    snk_stall_en   = 1'b1;
    stall_left     = 0;
    n_sent         = 0;
    n_checked      = 0;
    n_phases       = 0;
    n_errors       = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed_vectors();
    test_register_masking();
    test_random_phases();

    if (pending_blocks.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected blocks never came out", $time, pending_blocks.size());
    end
    $display("Covered %0d blocks in %0d key/mode settings, %0d results compared",
             n_sent, n_phases, n_checked);
    $display("Both commands, single and EDE modes, key extremes and register masking");
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
